@@ sv/slksd_pkg.sv @@
// ----------------------------------------------------------------------------
// slksd_pkg
// Shared types, byte codes and keyword tables for the serial line keyword
// state decoder.
// ----------------------------------------------------------------------------
package slksd_pkg;

   localparam int LINE_CAPACITY = 64;
   localparam int WORD_CAPACITY = 32;
   localparam int KEYWORD_COUNT = 16;
   localparam int KW_CHARS      = 10;
   localparam int LINE_FILL_W   = $clog2(LINE_CAPACITY);
   localparam int WORD_LEN_W    = $clog2(WORD_CAPACITY);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_DELETE     = 8'h7F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_CASE_BIT   = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

   typedef logic [2:0] mode_type;

   localparam mode_type MODE_IDLE = 3'd1;

   typedef enum logic [2:0] {
      CLS_NEWLINE,
      CLS_IGNORE,
      CLS_LETTER,
      CLS_UNDERSCORE,
      CLS_OTHER
   } class_type;

   typedef struct packed {
      class_type  cls;
      logic [7:0] lc;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Keywords are stored right-justified: the last character sits in [7:0].
   localparam logic [8*KW_CHARS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
      "booting", "idle", "neutral", "listening", "listen", "processing",
      "thinking", "speaking", "speak", "talking", "happy", "smile",
      "sleep", "sleeping", "error", "fault"
   };

   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd7, 4'd4, 4'd7, 4'd9, 4'd6, 4'd10, 4'd8, 4'd8,
      4'd5, 4'd7, 4'd5, 4'd5, 4'd5, 4'd8, 4'd5, 4'd5
   };

   localparam mode_type KW_MODE [KEYWORD_COUNT] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4,
      3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7
   };

   function automatic logic kw_char_match(input logic [3:0]            idx,
                                          input logic [WORD_LEN_W-1:0] pos,
                                          input logic [7:0]            lc);
      logic [3:0] rev;
      logic [7:0] ch;
      rev = KW_LEN[idx] - 4'd1 - pos[3:0];
      ch  = KW_TEXT[idx][8*rev +: 8];
      return (pos < WORD_LEN_W'(KW_LEN[idx])) && (ch == lc);
   endfunction

endpackage

@@ sv/serial_line_keyword_state_decoder.sv @@
// ----------------------------------------------------------------------------
// serial_line_keyword_state_decoder
// Builds text lines from received bytes, matches words against a fixed
// keyword list and switches the mode when a line closes.
//
//   channel   direction   ports
//   req       in          req_valid, req_ready, req_rx_byte
//   rsp       out         rsp_valid, rsp_ready, rsp_current_mode,
//                         rsp_line_done, rsp_line_accepted
//
// One byte per cycle sustained while responses are taken; each response
// passes through the queue entry register and then the output register.
// Reset is synchronous; after it the mode is idle and the line is empty.
// A stalled response holds in the output register while the two-entry queue
// keeps taking requests; req_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module serial_line_keyword_state_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_current_mode,
   output logic       rsp_line_done,
   output logic       rsp_line_accepted
);

   slksd_pkg::queue_status_type q_status;
   slksd_pkg::item_type         push_item;
   slksd_pkg::item_type         pop_item;
   logic                        push;
   logic                        pop;

   slksd_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   slksd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   slksd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (!q_status.empty),
      .q_item            (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_mode  (rsp_current_mode),
      .rsp_line_done     (rsp_line_done),
      .rsp_line_accepted (rsp_line_accepted)
   );

   a_accept_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_accepted |-> rsp_line_done)
      else $error("line accepted without line end");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_status.empty))
      else $error("response without queued request");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

@@ sv/slksd_front.sv @@
// ----------------------------------------------------------------------------
// slksd_front
// Accepts request bytes, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module slksd_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  slksd_pkg::queue_status_type q_status,
   output logic                        push,
   output slksd_pkg::item_type         push_item
);

   logic [7:0] lc;
   logic       is_letter;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   assign lc        = req_rx_byte | slksd_pkg::CHAR_CASE_BIT;
   assign is_letter = (lc >= slksd_pkg::CHAR_LOWER_A) && (lc <= slksd_pkg::CHAR_LOWER_Z)
                      && (req_rx_byte < 8'h80);

   always_comb begin
      push_item.lc = lc;
      if (req_rx_byte == slksd_pkg::CHAR_NEWLINE) begin
         push_item.cls = slksd_pkg::CLS_NEWLINE;
      end else if ((req_rx_byte < slksd_pkg::CHAR_SPACE) ||
                   (req_rx_byte >= slksd_pkg::CHAR_DELETE)) begin
         push_item.cls = slksd_pkg::CLS_IGNORE;
      end else if (is_letter) begin
         push_item.cls = slksd_pkg::CLS_LETTER;
      end else if (req_rx_byte == slksd_pkg::CHAR_UNDERSCORE) begin
         push_item.cls = slksd_pkg::CLS_UNDERSCORE;
      end else begin
         push_item.cls = slksd_pkg::CLS_OTHER;
      end
   end

endmodule

@@ sv/slksd_queue.sv @@
// ----------------------------------------------------------------------------
// slksd_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module slksd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  slksd_pkg::item_type         push_item,
   input  logic                        pop,
   output slksd_pkg::item_type         pop_item,
   output slksd_pkg::queue_status_type q_status
);

   localparam logic [slksd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      slksd_pkg::QUEUE_PTR_W'(slksd_pkg::QUEUE_DEPTH - 1);

   slksd_pkg::item_type                 entry_ff [slksd_pkg::QUEUE_DEPTH];
   logic [slksd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [slksd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [slksd_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == slksd_pkg::QUEUE_CNT_W'(slksd_pkg::QUEUE_DEPTH));
   assign pop_item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/slksd_back.sv @@
// ----------------------------------------------------------------------------
// slksd_back
// Applies one classified byte per cycle to the line and word state while the
// response register can take it, matches keywords and holds that register.
// ----------------------------------------------------------------------------
module slksd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  slksd_pkg::item_type   q_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_current_mode,
   output logic                  rsp_line_done,
   output logic                  rsp_line_accepted
);

   typedef enum logic [1:0] {
      PHASE_BETWEEN,
      PHASE_WORD,
      PHASE_SKIP
   } phase_type;

   localparam int LW = slksd_pkg::LINE_FILL_W;
   localparam int WW = slksd_pkg::WORD_LEN_W;
   localparam int KC = slksd_pkg::KEYWORD_COUNT;

   localparam logic [LW-1:0] LINE_LAST = LW'(slksd_pkg::LINE_CAPACITY - 1);
   localparam logic [WW-1:0] WORD_LAST = WW'(slksd_pkg::WORD_CAPACITY - 1);

   phase_type               phase_ff, phase_in;
   logic [LW-1:0]           fill_ff, fill_in;
   logic [WW-1:0]           wlen_ff, wlen_in;
   logic [KC-1:0]           cand_ff, cand_in;
   slksd_pkg::mode_type     pmode_ff, pmode_in;
   logic                    pvalid_ff, pvalid_in;
   slksd_pkg::mode_type     amode_ff, amode_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   slksd_pkg::mode_type     rsp_mode_ff, rsp_mode_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic                    rsp_acc_ff, rsp_acc_in;

   logic                    word_hit;
   slksd_pkg::mode_type     hit_mode;
   logic                    end_pvalid;
   slksd_pkg::mode_type     end_pmode;
   logic [KC-1:0]           cand_src;
   logic [WW-1:0]           pos;
   logic [KC-1:0]           filt;

   assign pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // Last keyword in table order that fully matches the current word.
   always_comb begin
      word_hit = 1'b0;
      hit_mode = '0;
      for (int i = 0; i < KC; i++) begin
         if (cand_ff[i] && (wlen_ff == WW'(slksd_pkg::KW_LEN[i]))) begin
            word_hit = 1'b1;
            hit_mode = slksd_pkg::KW_MODE[i];
         end
      end
   end

   assign end_pvalid = pvalid_ff || ((phase_ff == PHASE_WORD) && word_hit);
   assign end_pmode  = ((phase_ff == PHASE_WORD) && word_hit) ? hit_mode : pmode_ff;

   assign cand_src = (phase_ff == PHASE_BETWEEN) ? '1 : cand_ff;
   assign pos      = (phase_ff == PHASE_BETWEEN) ? '0 : wlen_ff;

   always_comb begin
      for (int i = 0; i < KC; i++) begin
         filt[i] = cand_src[i] && slksd_pkg::kw_char_match(4'(i), pos, q_item.lc);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      wlen_in   = wlen_ff;
      cand_in   = cand_ff;
      pmode_in  = pmode_ff;
      pvalid_in = pvalid_ff;
      amode_in  = amode_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         rsp_done_in  = 1'b0;
         rsp_acc_in   = 1'b0;
         rsp_valid_in = 1'b1;
         case (q_item.cls)
            slksd_pkg::CLS_NEWLINE: begin
               rsp_done_in = 1'b1;
               rsp_acc_in  = end_pvalid;
               if (end_pvalid) begin
                  amode_in = end_pmode;
               end
               phase_in  = PHASE_BETWEEN;
               fill_in   = '0;
               wlen_in   = '0;
               cand_in   = '0;
               pmode_in  = '0;
               pvalid_in = 1'b0;
            end
            slksd_pkg::CLS_IGNORE: begin
            end
            default: begin
               if (fill_ff >= LINE_LAST) begin
                  phase_in  = PHASE_BETWEEN;
                  fill_in   = '0;
                  wlen_in   = '0;
                  cand_in   = '0;
                  pmode_in  = '0;
                  pvalid_in = 1'b0;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  case (q_item.cls)
                     slksd_pkg::CLS_LETTER: begin
                        if (phase_ff == PHASE_BETWEEN) begin
                           phase_in = PHASE_WORD;
                           wlen_in  = WW'(1);
                           cand_in  = filt;
                        end else if (phase_ff == PHASE_WORD) begin
                           if (wlen_ff >= WORD_LAST) begin
                              pvalid_in = end_pvalid;
                              pmode_in  = end_pmode;
                              phase_in  = PHASE_SKIP;
                              wlen_in   = '0;
                              cand_in   = '0;
                           end else begin
                              cand_in = filt;
                              wlen_in = wlen_ff + 1'b1;
                           end
                        end
                     end
                     slksd_pkg::CLS_UNDERSCORE: begin
                        if (phase_ff == PHASE_WORD) begin
                           if (wlen_ff >= WORD_LAST) begin
                              pvalid_in = end_pvalid;
                              pmode_in  = end_pmode;
                              phase_in  = PHASE_BETWEEN;
                              wlen_in   = '0;
                              cand_in   = '0;
                           end else begin
                              cand_in = '0;
                              wlen_in = wlen_ff + 1'b1;
                           end
                        end else begin
                           phase_in = PHASE_BETWEEN;
                        end
                     end
                     default: begin
                        pvalid_in = end_pvalid;
                        pmode_in  = end_pmode;
                        phase_in  = PHASE_BETWEEN;
                        wlen_in   = '0;
                        cand_in   = '0;
                     end
                  endcase
               end
            end
         endcase
         rsp_mode_in = amode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_BETWEEN;
         fill_ff      <= '0;
         wlen_ff      <= '0;
         cand_ff      <= '0;
         pmode_ff     <= '0;
         pvalid_ff    <= 1'b0;
         amode_ff     <= slksd_pkg::MODE_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_mode_ff  <= '0;
         rsp_done_ff  <= 1'b0;
         rsp_acc_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         wlen_ff      <= wlen_in;
         cand_ff      <= cand_in;
         pmode_ff     <= pmode_in;
         pvalid_ff    <= pvalid_in;
         amode_ff     <= amode_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mode_ff  <= rsp_mode_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_acc_ff   <= rsp_acc_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_mode  = rsp_mode_ff;
   assign rsp_line_done     = rsp_done_ff;
   assign rsp_line_accepted = rsp_acc_ff;

endmodule

@@ dv/serial_line_keyword_state_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// serial_line_keyword_state_decoder_tb
// Drives received bytes into the decoder and compares every response with a
// cycle-free model of the line, word and keyword scan kept in the bench, or
// with the table value for entries of the opening table marked as known. It
// starts with that table of hand-picked bytes. Random lines follow, with
// keywords in mixed case, long words, overlong lines and raw noise. These run
// under changing sender and receiver stall rates, plus one long receiver
// hold-off.
module serial_line_keyword_state_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CHAR_RETURN = 8'h0D;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef enum logic [2:0] {
      MD_BOOTING,
      MD_IDLE,
      MD_LISTENING,
      MD_PROCESSING,
      MD_SPEAKING,
      MD_HAPPY,
      MD_SLEEP,
      MD_ERROR
   } line_mode_type;

   typedef enum logic [1:0] {
      SCAN_BETWEEN,
      SCAN_WORD,
      SCAN_SKIP
   } scan_state_type;

   typedef struct packed {
      line_mode_type mode;
      logic          done;
      logic          accepted;
   } decode_result_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       known;
      logic [2:0] mode;
      logic       done;
      logic       accepted;
   } vector_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_current_mode;
   logic       rsp_line_done;
   logic       rsp_line_accepted;

   string keywords [slksd_pkg::KEYWORD_COUNT] = '{
      "booting", "idle", "neutral", "listening", "listen", "processing",
      "thinking", "speaking", "speak", "talking", "happy", "smile",
      "sleep", "sleeping", "error", "fault"
   };

   line_mode_type keyword_mode [slksd_pkg::KEYWORD_COUNT] = '{
      MD_BOOTING, MD_IDLE, MD_IDLE, MD_LISTENING, MD_LISTENING,
      MD_PROCESSING, MD_PROCESSING, MD_SPEAKING, MD_SPEAKING, MD_SPEAKING,
      MD_HAPPY, MD_HAPPY, MD_SLEEP, MD_SLEEP, MD_ERROR, MD_ERROR
   };

   vector_type opening_bytes [28] = '{
      '{8'h00,                      1'b1, MD_IDLE,  1'b0, 1'b0},
      '{8'hFF,                      1'b1, MD_IDLE,  1'b0, 1'b0},
      '{CHAR_RETURN,                1'b1, MD_IDLE,  1'b0, 1'b0},
      '{slksd_pkg::CHAR_DELETE,     1'b1, MD_IDLE,  1'b0, 1'b0},
      '{8'h1F,                      1'b1, MD_IDLE,  1'b0, 1'b0},
      '{slksd_pkg::CHAR_NEWLINE,    1'b1, MD_IDLE,  1'b1, 1'b0},
      '{slksd_pkg::CHAR_SPACE,      1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"S",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"l",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"e",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"E",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"P",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{CHAR_RETURN,                1'b0, MD_IDLE,  1'b0, 1'b0},
      '{slksd_pkg::CHAR_NEWLINE,    1'b1, MD_SLEEP, 1'b1, 1'b1},
      '{"_",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"i",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"d",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"l",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"e",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"_",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{slksd_pkg::CHAR_NEWLINE,    1'b1, MD_SLEEP, 1'b1, 1'b0},
      '{8'h7E,                      1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"F",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"A",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"u",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"L",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{"T",                        1'b0, MD_IDLE,  1'b0, 1'b0},
      '{slksd_pkg::CHAR_NEWLINE,    1'b1, MD_ERROR, 1'b1, 1'b1}
   };

   int unsigned       chars_in_line = 0;
   int unsigned       chars_in_word = 0;
   scan_state_type    scan_state = SCAN_BETWEEN;
   logic [15:0]       live_keywords = '0;
   line_mode_type     line_mode = MD_BOOTING;
   logic              line_matched = 1'b0;
   line_mode_type     mode_now = MD_IDLE;

   decode_result_type expected_reports [$];
   logic [7:0]        line_bytes [$];
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       hold_off_cycles = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;

   serial_line_keyword_state_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_mode  (rsp_current_mode),
      .rsp_line_done     (rsp_line_done),
      .rsp_line_accepted (rsp_line_accepted)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_letter(logic [7:0] c);
      return ((c | slksd_pkg::CHAR_CASE_BIT) >= slksd_pkg::CHAR_LOWER_A) &&
             ((c | slksd_pkg::CHAR_CASE_BIT) <= slksd_pkg::CHAR_LOWER_Z);
   endfunction

   function automatic logic [15:0] narrow_keywords(logic [15:0] mask, int unsigned pos,
                                                   logic [7:0] lc);
      logic [15:0] keep;
      keep = '0;
      for (int i = 0; i < slksd_pkg::KEYWORD_COUNT; i++) begin
         if (mask[i] && pos < keywords[i].len() && 8'(keywords[i][pos]) == lc)
            keep[i] = 1'b1;
      end
      return keep;
   endfunction

   function automatic void finish_word();
      if (scan_state == SCAN_WORD) begin
         for (int i = 0; i < slksd_pkg::KEYWORD_COUNT; i++) begin
            if (live_keywords[i] && keywords[i].len() == chars_in_word) begin
               line_mode    = keyword_mode[i];
               line_matched = 1'b1;
            end
         end
      end
      scan_state    = SCAN_BETWEEN;
      chars_in_word = 0;
      live_keywords = '0;
   endfunction

   function automatic void drop_line();
      chars_in_line = 0;
      chars_in_word = 0;
      scan_state    = SCAN_BETWEEN;
      live_keywords = '0;
      line_mode     = MD_BOOTING;
      line_matched  = 1'b0;
   endfunction

   function automatic decode_result_type decode_byte(logic [7:0] b);
      decode_result_type r;
      r.done     = 1'b0;
      r.accepted = 1'b0;
      if (b == slksd_pkg::CHAR_NEWLINE) begin
         finish_word();
         r.done     = 1'b1;
         r.accepted = line_matched;
         if (line_matched)
            mode_now = line_mode;
         drop_line();
      end else if (b >= slksd_pkg::CHAR_SPACE && b < slksd_pkg::CHAR_DELETE) begin
         if (chars_in_line >= slksd_pkg::LINE_CAPACITY - 1) begin
            drop_line();
         end else begin
            chars_in_line++;
            if (is_letter(b)) begin
               case (scan_state)
                  SCAN_BETWEEN: begin
                     scan_state    = SCAN_WORD;
                     chars_in_word = 1;
                     live_keywords = narrow_keywords('1, 0, b | slksd_pkg::CHAR_CASE_BIT);
                  end
                  SCAN_WORD: begin
                     if (chars_in_word >= slksd_pkg::WORD_CAPACITY - 1) begin
                        finish_word();
                        scan_state = SCAN_SKIP;
                     end else begin
                        live_keywords = narrow_keywords(live_keywords, chars_in_word,
                                                        b | slksd_pkg::CHAR_CASE_BIT);
                        chars_in_word++;
                     end
                  end
                  default: ;
               endcase
            end else if (b == slksd_pkg::CHAR_UNDERSCORE) begin
               if (scan_state == SCAN_WORD) begin
                  if (chars_in_word >= slksd_pkg::WORD_CAPACITY - 1) begin
                     finish_word();
                  end else begin
                     live_keywords = '0;
                     chars_in_word++;
                  end
               end else begin
                  scan_state = SCAN_BETWEEN;
               end
            end else begin
               finish_word();
            end
         end
      end
      r.mode = mode_now;
      return r;
   endfunction

   function automatic void add_text(string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = 8'(s[i]);
         if (is_letter(c) && $urandom_range(2) == 0)
            c = c & ~slksd_pkg::CHAR_CASE_BIT;
         line_bytes.push_back(c);
      end
   endfunction

   function automatic void add_word(int unsigned n);
      logic [7:0] c;
      repeat (n) begin
         c = slksd_pkg::CHAR_LOWER_A + 8'($urandom_range(25));
         if ($urandom_range(1))
            c = c & ~slksd_pkg::CHAR_CASE_BIT;
         line_bytes.push_back(c);
      end
   endfunction

   function automatic void add_gap();
      logic [7:0] c;
      case ($urandom_range(7))
         0, 1, 2: c = slksd_pkg::CHAR_SPACE;
         3:       c = slksd_pkg::CHAR_UNDERSCORE;
         4:       c = CHAR_RETURN;
         5:       c = 8'($urandom_range(128, 255));
         default: begin
            do c = 8'($urandom_range(33, 126)); while (is_letter(c));
         end
      endcase
      line_bytes.push_back(c);
   endfunction

   function automatic void make_line();
      int unsigned kind;
      int unsigned target;
      string       s;
      line_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 55) begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(3) != 0)
               add_text(keywords[$urandom_range(slksd_pkg::KEYWORD_COUNT - 1)]);
            else
               add_word($urandom_range(1, 10));
            if ($urandom_range(7) == 0)
               add_word(1);
            add_gap();
         end
      end else if (kind < 65) begin
         if ($urandom_range(1)) begin
            add_text(keywords[$urandom_range(slksd_pkg::KEYWORD_COUNT - 1)]);
            add_gap();
         end
         add_word($urandom_range(slksd_pkg::WORD_CAPACITY - 6,
                                 slksd_pkg::WORD_CAPACITY + 8));
         if ($urandom_range(1))
            line_bytes.push_back(slksd_pkg::CHAR_UNDERSCORE);
         if ($urandom_range(1))
            add_text(keywords[$urandom_range(slksd_pkg::KEYWORD_COUNT - 1)]);
      end else if (kind < 75) begin
         target = $urandom_range(slksd_pkg::LINE_CAPACITY - 14,
                                 slksd_pkg::LINE_CAPACITY + 16);
         while (line_bytes.size() < target) begin
            if ($urandom_range(2) == 0)
               add_text(keywords[$urandom_range(slksd_pkg::KEYWORD_COUNT - 1)]);
            else
               add_word($urandom_range(1, 8));
            add_gap();
         end
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 20))
            line_bytes.push_back(8'($urandom_range(255)));
         return;
      end else begin
         s = keywords[$urandom_range(slksd_pkg::KEYWORD_COUNT - 1)];
         if ($urandom_range(1))
            add_text(s.substr(0, s.len() - 2));
         else
            add_text(s);
         if ($urandom_range(1))
            return;
      end
      if ($urandom_range(3) == 0)
         line_bytes.push_back(CHAR_RETURN);
      line_bytes.push_back(slksd_pkg::CHAR_NEWLINE);
   endfunction

   task automatic send_byte(logic [7:0] rx, logic known, decode_result_type want);
      decode_result_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = decode_byte(rx);
      expected_reports.push_back(known ? want : predicted);
   endtask

   task automatic run_lines(int unsigned budget, int unsigned send_pct, int unsigned recv_pct);
      int unsigned sent;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < budget) begin
         make_line();
         foreach (line_bytes[i])
            send_byte(line_bytes[i], 1'b0, '0);
         sent += line_bytes.size();
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      decode_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: mode %0d done %0b accepted %0b",
                        rsp_current_mode, rsp_line_done, rsp_line_accepted);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_current_mode !== want.mode || rsp_line_done !== want.done ||
                rsp_line_accepted !== want.accepted) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: mode %0d/%0d done %0b/%0b accepted %0b/%0b (exp/act)",
                           want.mode, rsp_current_mode, want.done, rsp_line_done,
                           want.accepted, rsp_line_accepted);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_bytes[i])
         send_byte(opening_bytes[i].rx, opening_bytes[i].known,
                   '{line_mode_type'(opening_bytes[i].mode), opening_bytes[i].done,
                     opening_bytes[i].accepted});
      run_lines(400, 0, 0);
      run_lines(350, 87, 0);
      run_lines(350, 0, 87);
      run_lines(400, 24, 24);
      pause_until_drained();
      hold_off_cycles = 80;
      run_lines(150, 0, 0);
      pause_until_drained();
      run_lines(150, 0, 0);
      pause_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
sv/slksd_pkg.sv
sv/slksd_front.sv
sv/slksd_queue.sv
sv/slksd_back.sv
sv/serial_line_keyword_state_decoder.sv
dv/serial_line_keyword_state_decoder_tb.sv
